### rtl/core/chunk_frame_deframer_macros.svh
// Assertion macros for the chunk deframer. Both expect clk_i and rst_ni in scope.
`ifndef CHUNK_FRAME_DEFRAMER_MACROS_SVH
`define CHUNK_FRAME_DEFRAMER_MACROS_SVH
`ifndef SYNTH
`define CFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CFD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define CFD_ASSERT(lbl, prop, msg)
`define CFD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/core/cfd_pkg.sv
package cfd_pkg;

  // Header length field bits kept (8..32).
  localparam int unsigned LengthBits = 32;
  localparam int unsigned HdrLen     = 48;
  localparam int unsigned TrlLen     = 36;
  localparam int unsigned HashLen    = 32;
  localparam int unsigned TdataW     = 256;
  localparam int unsigned QDepth     = 4;

  localparam logic [7:0] HeadMagic [4] = '{8'h43, 8'h48, 8'h4B, 8'h00};
  localparam logic [7:0] TailMagic [4] = '{8'h2F, 8'h43, 8'h48, 8'h4B};

  typedef enum logic [1:0] {
    PhHeader  = 2'd0,
    PhPayload = 2'd1,
    PhTrailer = 2'd2,
    PhSkip    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    KindHeader  = 3'd0,
    KindPayload = 3'd1,
    KindHash    = 3'd2,
    KindDone    = 3'd3,
    KindError   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ErrNone     = 3'd0,
    ErrMagic    = 3'd1,
    ErrType     = 3'd2,
    ErrReserved = 3'd3,
    ErrTrunc    = 3'd4,
    ErrMarker   = 3'd5
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  byte_out;
    logic [31:0] chunk_number;
    logic [1:0]  chunk_kind;
    logic [31:0] payload_length;
    logic [7:0]  compression_id;
    logic [7:0]  erasure_id;
    logic [63:0] id_high;
    logic [63:0] id_low;
    err_e        error_code;
    logic [32:0] consumed_bytes;
    logic        last;
  } res_t;

endpackage

### rtl/core/chunk_frame_deframer.sv
// Chunk deframer: takes one stream byte per word (tlast marks end of data), checks
// the 48-byte header, passes payload and 32 hash bytes, checks the /CHK marker and
// reports the chunk length; errors are reported as kind 4 words, after which bytes are
// dropped up to the end-of-data mark. One input word is taken per cycle while ready is
// high, and its results are registered into a 4-entry result queue. A byte yields at
// most two result words (a header record, payload or hash byte followed by a truncation
// error); input ready is held low while more than two words are queued, so the
// sustained rate is one byte per cycle as long as the sink takes one result per cycle.
module chunk_frame_deframer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // [7:0] data_byte
  input  logic                      s_axis_tlast,  // end_of_data
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [7:0] byte_out, [39:8] chunk_number, [41:40] chunk_kind, [73:42] payload_length,
  // [81:74] compression_id, [89:82] erasure_id, [153:90] id_high, [217:154] id_low,
  // [220:218] error_code, [253:221] consumed_bytes, [255:254] zero
  output logic [cfd_pkg::TdataW-1:0] m_axis_tdata,
  output logic [2:0]                m_axis_tuser,  // [2:0] kind
  output logic                      m_axis_tlast   // last
);
  import cfd_pkg::*;

  localparam logic [5:0] HdrLast = 6'(HdrLen - 1);
  localparam logic [5:0] TrlLast = 6'(TrlLen - 1);
  localparam logic [5:0] HashEnd = 6'(HashLen);

  phase_e                phase_q, phase_d;
  logic [5:0]            pos_q, pos_d;
  err_e                  pend_q, pend_d;
  logic                  tbad_q, tbad_d;
  logic [LengthBits-1:0] pay_q, pay_d;

  logic [63:0] id_hi_q, id_lo_q;
  logic [31:0] idx_q, len_raw_q;
  logic [7:0]  type_lo_q, alg0_q, alg1_q;
  logic        type_hi_nz_q;

  logic        in_acc, eod;
  logic [7:0]  b;
  err_e        hdr_err;
  logic        type_bad, tr_bad;
  logic [LengthBits-1:0] len_now;

  res_t        r0, r1;
  logic [1:0]  n_res;

  res_t        q_mem [QDepth];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q;
  logic        pop;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign eod     = s_axis_tlast;
  assign b       = s_axis_tdata;
  assign len_now = len_raw_q[LengthBits-1:0];

  // bytes 24..26 are registered, byte 27 is the current one
  assign type_bad = type_hi_nz_q || (b != 8'h00) ||
                    !((type_lo_q == 8'd1) || (type_lo_q == 8'd2));

  // header error after this byte; the first error found wins
  always_comb begin
    hdr_err = pend_q;
    if (pend_q == ErrNone) begin
      if (pos_q < 6'd4) begin
        if (b != HeadMagic[pos_q[1:0]]) hdr_err = ErrMagic;
      end else if (pos_q == 6'd27) begin
        if (type_bad) hdr_err = ErrType;
      end else if (pos_q >= 6'd34) begin
        if (b != 8'h00) hdr_err = ErrReserved;
      end
    end
  end

  assign tr_bad = tbad_q || ((pos_q >= HashEnd) && (b != TailMagic[pos_q[1:0]]));

  // next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    pend_d  = pend_q;
    tbad_d  = tbad_q;
    pay_d   = pay_q;
    if (in_acc) begin
      case (phase_q)
        PhHeader: begin
          pend_d = hdr_err;
          if (pos_q == HdrLast) begin
            if (hdr_err != ErrNone) begin
              phase_d = eod ? PhHeader : PhSkip;
              if (eod) pend_d = ErrNone;
              pos_d = '0;
            end else if (eod) begin
              phase_d = PhHeader;
              pos_d   = '0;
            end else begin
              phase_d = (len_now == '0) ? PhTrailer : PhPayload;
              pos_d   = '0;
              pay_d   = len_now;
              tbad_d  = 1'b0;
            end
          end else if (eod) begin
            pos_d  = '0;
            pend_d = ErrNone;
          end else begin
            pos_d = pos_q + 6'd1;
          end
        end
        PhPayload: begin
          pay_d = pay_q - LengthBits'(1);
          if (pay_q == LengthBits'(1)) begin
            phase_d = PhTrailer;
            pos_d   = '0;
          end
          if (eod) begin
            phase_d = PhHeader;
            pos_d   = '0;
          end
        end
        PhTrailer: begin
          if (pos_q == TrlLast) begin
            phase_d = (tr_bad && !eod) ? PhSkip : PhHeader;
            pos_d   = '0;
            tbad_d  = 1'b0;
          end else if (eod) begin
            phase_d = PhHeader;
            pos_d   = '0;
            tbad_d  = 1'b0;
          end else begin
            pos_d  = pos_q + 6'd1;
            tbad_d = tr_bad;
          end
        end
        PhSkip: begin
          if (eod) begin
            phase_d = PhHeader;
            pos_d   = '0;
            pend_d  = ErrNone;
            tbad_d  = 1'b0;
          end
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
  end

  // result words for the accepted byte
  always_comb begin
    r0         = '0;
    r1         = '0;
    r1.kind    = KindError;
    r1.error_code = ErrTrunc;
    n_res      = 2'd0;
    if (in_acc) begin
      case (phase_q)
        PhHeader: begin
          if (pos_q == HdrLast) begin
            n_res = 2'd1;
            if (hdr_err != ErrNone) begin
              r0.kind       = KindError;
              r0.error_code = hdr_err;
            end else begin
              r0.kind           = KindHeader;
              r0.chunk_number   = idx_q;
              r0.chunk_kind     = type_lo_q[1:0];
              r0.payload_length = 32'(len_now);
              r0.compression_id = alg0_q;
              r0.erasure_id     = alg1_q;
              r0.id_high        = id_hi_q;
              r0.id_low         = id_lo_q;
              if (eod) n_res = 2'd2;
            end
          end else if (eod) begin
            n_res         = 2'd1;
            r0.kind       = KindError;
            r0.error_code = ErrTrunc;
          end
        end
        PhPayload: begin
          r0.kind     = KindPayload;
          r0.byte_out = b;
          n_res       = eod ? 2'd2 : 2'd1;
        end
        PhTrailer: begin
          if (pos_q == TrlLast) begin
            n_res = 2'd1;
            if (tr_bad) begin
              r0.kind       = KindError;
              r0.error_code = ErrMarker;
            end else begin
              r0.kind           = KindDone;
              r0.consumed_bytes = 33'(len_now) + 33'(HdrLen + TrlLen);
            end
          end else if (pos_q < HashEnd) begin
            r0.kind     = KindHash;
            r0.byte_out = b;
            n_res       = eod ? 2'd2 : 2'd1;
          end else if (eod) begin
            n_res         = 2'd1;
            r0.kind       = KindError;
            r0.error_code = ErrTrunc;
          end
        end
        default: begin
          n_res = 2'd0;
        end
      endcase
    end
    if (n_res == 2'd2) r1.last = 1'b1;
    else               r0.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      pend_q  <= ErrNone;
      tbad_q  <= 1'b0;
      pay_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      tbad_q  <= tbad_d;
      pay_q   <= pay_d;
    end
  end

  // header field capture; every field is rewritten by each header
  always_ff @(posedge clk_i) begin
    if (in_acc && (phase_q == PhHeader)) begin
      if ((pos_q >= 6'd4) && (pos_q < 6'd12)) id_hi_q <= {id_hi_q[55:0], b};
      if ((pos_q >= 6'd12) && (pos_q < 6'd20)) id_lo_q <= {id_lo_q[55:0], b};
      if ((pos_q >= 6'd20) && (pos_q < 6'd24)) idx_q[8*pos_q[1:0] +: 8] <= b;
      if ((pos_q >= 6'd28) && (pos_q < 6'd32)) len_raw_q[8*pos_q[1:0] +: 8] <= b;
      if (pos_q == 6'd24) type_lo_q <= b;
      if (pos_q == 6'd25) type_hi_nz_q <= (b != 8'h00);
      if (pos_q == 6'd26) type_hi_nz_q <= type_hi_nz_q || (b != 8'h00);
      if (pos_q == 6'd32) alg0_q <= b;
      if (pos_q == 6'd33) alg1_q <= b;
    end
  end

  // result queue
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (cnt_q != 3'd0);
  assign s_axis_tready = (cnt_q <= 3'd2);

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) q_mem[wr_ptr_q] <= r0;
    if (n_res == 2'd2) q_mem[wr_ptr_q + 2'd1] <= r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + n_res;
      rd_ptr_q <= rd_ptr_q + {1'b0, pop};
      cnt_q    <= cnt_q + {1'b0, n_res} - {2'b00, pop};
    end
  end

  res_t head;
  assign head = q_mem[rd_ptr_q];

  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {2'b00, head.consumed_bytes, head.error_code, head.id_low,
                         head.id_high, head.erasure_id, head.compression_id,
                         head.payload_length, head.chunk_kind, head.chunk_number,
                         head.byte_out};

`include "chunk_frame_deframer_macros.svh"

  `CFD_ASSERT(a_queue_bound, cnt_q <= 3'(QDepth), "result queue overflow")
  `CFD_ASSERT(a_hdr_pos, (phase_q != PhHeader) || (pos_q <= HdrLast), "header position out of range")
  `CFD_ASSERT(a_trl_pos, (phase_q != PhTrailer) || (pos_q <= TrlLast), "trailer position out of range")
  `CFD_ASSERT_NEXT(a_skip_exit, in_acc && (phase_q == PhSkip) && eod, phase_q == PhHeader, "skip did not end at end of data")
  `CFD_ASSERT_NEXT(a_payload_push, in_acc && (phase_q == PhPayload), cnt_q != 3'd0, "payload byte gave no result")

endmodule

### dv/tb.sv
module tb;
  import cfd_pkg::*;

  localparam int          HalfPeriod    = 6;
  localparam int          ResetCycles   = 10;
  localparam int          DrainCycles   = 16;
  localparam int          LongHold      = 300;
  localparam int          WatchdogLimit = 4000;
  localparam int          BytesPhaseA   = 1450;
  localparam int          BytesTotal    = 1800;
  localparam logic [31:0] LenMask       = 32'((64'd1 << LengthBits) - 64'd1);

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } stream_byte_t;

  typedef enum int {
    ScGood, ScGoodEnd, ScTrunc, ScHdrEnd, ScHdrErr, ScMarkerErr, ScLongLen, ScNoise, ScCount
  } chunk_case_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic         s_axis_tlast = 1'b0; // end_of_data
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;   // byte_out .. consumed_bytes, see DUT port list
  logic [2:0]   m_axis_tuser;        // [2:0] kind
  logic         m_axis_tlast;        // last

  chunk_frame_deframer u_dut (.*);

  always #HalfPeriod clk_i = ~clk_i;

  stream_byte_t pending_bytes[$];
  res_t         expected_words[$];

  int  bytes_queued = 0;
  int  bytes_taken = 0;
  int  words_checked = 0;
  int  mismatches = 0;
  int  chunks_done = 0;
  int  hash_words = 0;
  int  err_seen [8];
  bit  byte_taken = 1'b0;
  bit  idle_en = 1'b1;
  bit  rx_hold_req = 1'b0;
  bit  rx_hold_done = 1'b0;
  int  tx_gap = 0;
  int  rx_hold = 0;
  int  quiet_cycles = 0;

  // parser state mirrored by the predictor
  phase_e      ph = PhHeader;
  err_e        perr = ErrNone;
  logic [32:0] pos = '0;
  logic [63:0] id_s [2];
  logic [31:0] idx_s, typ_s, len_s;
  logic [7:0]  alg_s [2];

  function automatic void clear_parser();
    ph = PhHeader;
    perr = ErrNone;
    pos = '0;
    id_s[0] = '0;
    id_s[1] = '0;
    idx_s = '0;
    typ_s = '0;
    len_s = '0;
    alg_s[0] = '0;
    alg_s[1] = '0;
  endfunction

  function automatic void deframe_predict(logic [7:0] b, logic eod);
    res_t        rows [2];
    int          n;
    int          p;
    logic [32:0] t;
    n = 0;
    rows[0] = '0;
    rows[1] = '0;
    case (ph)
      PhHeader: begin
        p = int'(pos);
        if (p < 4) begin
          if (b != HeadMagic[p] && perr == ErrNone) perr = ErrMagic;
        end else if (p < 12) begin
          id_s[0] = {id_s[0][55:0], b};
        end else if (p < 20) begin
          id_s[1] = {id_s[1][55:0], b};
        end else if (p < 24) begin
          idx_s[8*(p-20) +: 8] = b;
        end else if (p < 28) begin
          typ_s[8*(p-24) +: 8] = b;
          if (p == 27 && perr == ErrNone && typ_s != 32'd1 && typ_s != 32'd2) perr = ErrType;
        end else if (p < 32) begin
          len_s[8*(p-28) +: 8] = b;
        end else if (p < 34) begin
          alg_s[p-32] = b;
        end else if (b != 8'h00 && perr == ErrNone) begin
          perr = ErrReserved;
        end

        if (p >= HdrLen - 1) begin
          if (perr != ErrNone) begin
            rows[n].kind = KindError;
            rows[n].error_code = perr;
            n++;
            if (eod) clear_parser();
            else ph = PhSkip;
          end else begin
            len_s = len_s & LenMask;
            rows[n].kind = KindHeader;
            rows[n].chunk_number = idx_s;
            rows[n].chunk_kind = typ_s[1:0];
            rows[n].payload_length = len_s;
            rows[n].compression_id = alg_s[0];
            rows[n].erasure_id = alg_s[1];
            rows[n].id_high = id_s[0];
            rows[n].id_low = id_s[1];
            n++;
            if (eod) begin
              rows[n].kind = KindError;
              rows[n].error_code = ErrTrunc;
              n++;
              clear_parser();
            end else begin
              ph = (len_s == '0) ? PhTrailer : PhPayload;
              pos = 33'(HdrLen);
            end
          end
        end else if (eod) begin
          rows[n].kind = KindError;
          rows[n].error_code = ErrTrunc;
          n++;
          clear_parser();
        end else begin
          pos = pos + 33'd1;
        end
      end
      PhPayload: begin
        rows[n].kind = KindPayload;
        rows[n].byte_out = b;
        n++;
        pos = pos + 33'd1;
        if (pos >= 33'(HdrLen) + 33'(len_s)) ph = PhTrailer;
        if (eod) begin
          rows[n].kind = KindError;
          rows[n].error_code = ErrTrunc;
          n++;
          clear_parser();
        end
      end
      PhTrailer: begin
        t = pos - 33'(HdrLen) - 33'(len_s);
        if (t < 33'(HashLen)) begin
          rows[n].kind = KindHash;
          rows[n].byte_out = b;
          n++;
        end else if (t < 33'(TrlLen)) begin
          if (b != TailMagic[2'(t - 33'(HashLen))] && perr == ErrNone) perr = ErrMarker;
        end
        if (t >= 33'(TrlLen - 1)) begin
          if (perr != ErrNone) begin
            rows[n].kind = KindError;
            rows[n].error_code = perr;
            n++;
            if (eod) clear_parser();
            else ph = PhSkip;
          end else begin
            rows[n].kind = KindDone;
            rows[n].consumed_bytes = pos + 33'd1;
            n++;
            clear_parser();
          end
        end else begin
          pos = pos + 33'd1;
          if (eod) begin
            rows[n].kind = KindError;
            rows[n].error_code = ErrTrunc;
            n++;
            clear_parser();
          end
        end
      end
      default: begin
        if (eod) clear_parser();
      end
    endcase
    if (n > 0) rows[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(rows[i]);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic queue_byte(logic [7:0] b, logic eod);
    pending_bytes.push_back('{data: b, eod: eod});
    bytes_queued++;
  endtask

  // Builds one chunk (or a burst of garbage) with random content and queues it.
  task automatic add_chunk(chunk_case_e sc);
    logic [7:0]  cb[$];
    logic [31:0] plen;
    logic [31:0] typ;
    logic [2:0]  bad;
    int          extra;
    int          cut;
    int          tail;
    int          k;
    bit          has_eod;
    plen = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(17, 64)) : 32'($urandom_range(0, 16));
    if (sc == ScLongLen) plen = $urandom | 32'h0000_0100;
    bad = '0;
    if (sc == ScHdrErr) bad = 3'($urandom_range(1, 7));
    else if ((sc == ScTrunc || sc == ScHdrEnd) && $urandom_range(0, 2) == 0)
      bad = 3'($urandom_range(1, 7));
    typ = 32'($urandom_range(1, 2));
    if (bad[1]) begin
      do begin
        typ = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 4));
      end while (typ == 32'd1 || typ == 32'd2);
    end

    for (k = 0; k < 4; k++) cb.push_back(HeadMagic[k]);
    if (bad[0]) begin
      k = $urandom_range(0, 3);
      cb[k] = cb[k] ^ 8'($urandom_range(1, 255));
    end
    for (k = 0; k < 20; k++) cb.push_back(8'($urandom));  // identifier and index
    for (k = 0; k < 4; k++) cb.push_back(typ[8*k +: 8]);
    for (k = 0; k < 4; k++) cb.push_back(plen[8*k +: 8]);
    cb.push_back(8'($urandom));
    cb.push_back(8'($urandom));
    for (k = 0; k < 14; k++) cb.push_back(8'h00);
    if (bad[2]) cb[34 + $urandom_range(0, 13)] = 8'($urandom_range(1, 255));

    // long lengths cannot be streamed out, so those chunks are cut in the payload
    extra = (sc == ScLongLen) ? $urandom_range(0, 10) : int'(plen);
    for (k = 0; k < extra; k++) cb.push_back(8'($urandom));
    if (sc != ScLongLen) begin
      for (k = 0; k < HashLen; k++) cb.push_back(8'($urandom));
      for (k = 0; k < 4; k++) cb.push_back(TailMagic[k]);
      if (sc == ScMarkerErr) begin
        k = cb.size() - 1 - $urandom_range(0, 3);
        cb[k] = cb[k] ^ 8'($urandom_range(1, 255));
      end
    end

    has_eod = 1'b1;
    tail = 0;
    cut = cb.size() - 1;
    case (sc)
      ScGood: has_eod = 1'b0;
      ScTrunc: cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, HdrLen - 1)
                                                  : $urandom_range(0, cb.size() - 1);
      ScHdrEnd: cut = HdrLen - 1;
      ScHdrErr, ScMarkerErr: tail = $urandom_range(0, 4);
      ScNoise: begin
        cb.delete();
        extra = $urandom_range(1, 8);
        for (k = 0; k < extra; k++) cb.push_back(8'($urandom));
        cut = extra - 1;
      end
      default: ;
    endcase
    for (k = 0; k <= cut; k++) queue_byte(cb[k], has_eod && tail == 0 && k == cut);
    for (k = 0; k < tail; k++) queue_byte(8'($urandom), k == tail - 1);
  endtask

  function automatic chunk_case_e pick_case();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return ScGood;
    if (r < 45) return ScGoodEnd;
    if (r < 62) return ScTrunc;
    if (r < 68) return ScHdrEnd;
    if (r < 80) return ScHdrErr;
    if (r < 88) return ScMarkerErr;
    if (r < 94) return ScLongLen;
    return ScNoise;
  endfunction

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // input side
  always @(negedge clk_i) begin
    stream_byte_t w;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        w = pending_bytes.pop_front();
        s_axis_tdata <= w.data;
        s_axis_tlast <= w.eod;
        s_axis_tvalid <= 1'b1;
        if (idle_en && $urandom_range(0, 11) == 0) tx_gap <= $urandom_range(1, 18);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold <= LongHold - 1;
      rx_hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 17);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    byte_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        byte_taken = 1'b1;
        bytes_taken++;
        deframe_predict(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.byte_out = m_axis_tdata[7:0];
        got.chunk_number = m_axis_tdata[39:8];
        got.chunk_kind = m_axis_tdata[41:40];
        got.payload_length = m_axis_tdata[73:42];
        got.compression_id = m_axis_tdata[81:74];
        got.erasure_id = m_axis_tdata[89:82];
        got.id_high = m_axis_tdata[153:90];
        got.id_low = m_axis_tdata[217:154];
        got.error_code = err_e'(m_axis_tdata[220:218]);
        got.consumed_bytes = m_axis_tdata[253:221];
        got.last = m_axis_tlast;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual kind %0d", $time,
                   m_axis_tuser);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          check_field("kind", 64'(want.kind), 64'(got.kind));
          check_field("byte_out", 64'(want.byte_out), 64'(got.byte_out));
          check_field("chunk_number", 64'(want.chunk_number), 64'(got.chunk_number));
          check_field("chunk_kind", 64'(want.chunk_kind), 64'(got.chunk_kind));
          check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
          check_field("compression_id", 64'(want.compression_id), 64'(got.compression_id));
          check_field("erasure_id", 64'(want.erasure_id), 64'(got.erasure_id));
          check_field("id_high", want.id_high, got.id_high);
          check_field("id_low", want.id_low, got.id_low);
          check_field("error_code", 64'(want.error_code), 64'(got.error_code));
          check_field("consumed_bytes", 64'(want.consumed_bytes), 64'(got.consumed_bytes));
          check_field("last", 64'(want.last), 64'(got.last));
          if (want.kind == KindDone) chunks_done++;
          if (want.kind == KindHash) hash_words++;
          if (want.kind == KindError) err_seen[want.error_code]++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    foreach (err_seen[i]) err_seen[i] = 0;
    clear_parser();
    // short streams that end inside the header, one with a bad magic already latched
    queue_byte(8'h43, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h4B, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h55, 1'b1);
    queue_byte(8'hFF, 1'b1);

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_idle();

    for (int rep = 0; rep < 2; rep++)
      for (int s = 0; s < ScCount; s++) add_chunk(chunk_case_e'(s));
    while (bytes_queued < BytesPhaseA) add_chunk(pick_case());
    // sink stalls long while the source keeps offering, so the DUT backs up
    repeat (200) @(posedge clk_i);
    rx_hold_req = 1'b1;
    wait_idle();

    idle_en = 1'b0;
    while (bytes_queued < BytesTotal) add_chunk(pick_case());
    wait_idle();

    $display("Sent %0d stream bytes, checked %0d result words: %0d chunks completed, %0d hash bytes",
             bytes_taken, words_checked, chunks_done, hash_words);
    $display("Error words: magic %0d, type %0d, reserved %0d, truncated %0d, end marker %0d",
             err_seen[ErrMagic], err_seen[ErrType], err_seen[ErrReserved], err_seen[ErrTrunc],
             err_seen[ErrMarker]);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### chunk_frame_deframer.f
+incdir+rtl/core
rtl/core/cfd_pkg.sv
rtl/core/chunk_frame_deframer.sv
dv/tb.sv
